FILE: src/dstc_pkg.sv
// Package for the DST switch controller: phase encoding, word and state types,
// calendar constants. No dependencies.
package dstc_pkg;

    localparam logic [3:0] MONTH_MAR    = 4'd3;
    localparam logic [3:0] MONTH_OCT    = 4'd10;
    localparam logic [4:0] LAST_DAY     = 5'd31;
    localparam logic [2:0] SUNDAY       = 3'd7;
    localparam logic [4:0] SPRING_HOUR  = 5'd2;
    localparam logic [4:0] AUTUMN_HOUR  = 5'd3;
    localparam logic [4:0] HOUR_MAX     = 5'd23;

    typedef enum logic [1:0] {
        PH_WAIT     = 2'd0,
        PH_SWITCH   = 2'd1,
        PH_SWITCHED = 2'd2
    } dstc_phase_t;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] last_day_weekday;
        logic       saved_dst;
    } dstc_item_t;

    typedef struct packed {
        logic        dst_flag;
        dstc_phase_t spring_phase;
        dstc_phase_t autumn_phase;
    } dstc_state_t;

    typedef struct packed {
        logic       dst_now;
        logic       set_clock;
        logic [4:0] clock_hour;
        logic [5:0] clock_minute;
        logic [5:0] clock_second;
        logic       save_dst;
        logic       save_dst_value;
    } dstc_result_t;

endpackage

FILE: src/dstc_step.sv
// Per-minute DST decision: both switch machines and the saved-flag check.
// Pure combinational; depends on dstc_pkg.
module dstc_step
    import dstc_pkg::*;
(
    input  dstc_item_t   item,
    input  dstc_state_t  state,
    output dstc_state_t  state_next,
    output dstc_result_t result
);

    logic [4:0] last_sun;
    logic       eff_saved;

    // weekday of the 31st mod 7; Sunday maps to 0
    assign last_sun = LAST_DAY -
        ((item.last_day_weekday == SUNDAY) ? 5'd0 : {2'b00, item.last_day_weekday});

    always_comb
    begin
        state_next = state;
        result     = '0;

        if (item.month == MONTH_MAR)
        begin
            case (state.spring_phase)
                PH_WAIT:
                begin
                    if (item.day == last_sun && item.hour == SPRING_HOUR && item.minute == 6'd0)
                        state_next.spring_phase = PH_SWITCH;
                    else if (item.day < last_sun)
                        state_next.dst_flag = 1'b0;
                    else if (item.day > last_sun)
                        state_next.dst_flag = 1'b1;
                    else if (item.hour < SPRING_HOUR)
                        state_next.dst_flag = 1'b0;
                end
                PH_SWITCH:
                begin
                    result.set_clock      = 1'b1;
                    result.clock_hour     = AUTUMN_HOUR;
                    result.clock_second   = item.second;
                    result.save_dst       = 1'b1;
                    result.save_dst_value = 1'b1;
                    state_next.spring_phase = PH_SWITCHED;
                    state_next.dst_flag     = 1'b1;
                end
                PH_SWITCHED:
                begin
                    if (item.minute != 6'd0)
                        state_next.spring_phase = PH_WAIT;
                    state_next.dst_flag = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (item.month == MONTH_OCT)
        begin
            case (state.autumn_phase)
                PH_WAIT:
                begin
                    if (item.day == last_sun && item.hour == AUTUMN_HOUR && item.minute == 6'd0)
                        state_next.autumn_phase = PH_SWITCH;
                    else if (item.day > last_sun)
                        state_next.dst_flag = 1'b0;
                    else if (item.day < last_sun)
                        state_next.dst_flag = 1'b1;
                    else if (item.hour < AUTUMN_HOUR)
                        state_next.dst_flag = 1'b1;
                end
                PH_SWITCH:
                begin
                    result.set_clock      = 1'b1;
                    result.clock_hour     = SPRING_HOUR;
                    result.clock_second   = item.second;
                    result.save_dst       = 1'b1;
                    result.save_dst_value = 1'b0;
                    state_next.autumn_phase = PH_SWITCHED;
                    state_next.dst_flag     = 1'b0;
                end
                PH_SWITCHED:
                begin
                    if (item.hour > AUTUMN_HOUR)
                        state_next.autumn_phase = PH_WAIT;
                    state_next.dst_flag = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (item.month < MONTH_MAR || item.month > MONTH_OCT)
            state_next.dst_flag = 1'b0;
        else
            state_next.dst_flag = 1'b1;

        // a flag written by a switch machine this minute counts as already saved
        eff_saved = result.save_dst ? result.save_dst_value : item.saved_dst;
        if (state_next.dst_flag && !eff_saved)
        begin
            result.set_clock      = 1'b1;
            result.clock_hour     = (item.hour >= HOUR_MAX) ? 5'd0 : item.hour + 5'd1;
            result.clock_minute   = item.minute;
            result.clock_second   = item.second;
            result.save_dst       = 1'b1;
            result.save_dst_value = 1'b1;
        end
        else if (!state_next.dst_flag && eff_saved)
        begin
            result.set_clock      = 1'b1;
            result.clock_hour     = (item.hour != 5'd0) ? item.hour - 5'd1 : HOUR_MAX;
            result.clock_minute   = item.minute;
            result.clock_second   = item.second;
            result.save_dst       = 1'b1;
            result.save_dst_value = 1'b0;
        end

        result.dst_now = state_next.dst_flag;
    end

endmodule

FILE: src/dst_switch_controller.sv
// Top level of the EU daylight saving time switch controller.
// Depends on dstc_pkg and dstc_step.

// One word per minute carries the date, time, weekday of the 31st and the stored
// DST flag; one result word comes back per input word, in order. The block takes
// a word every clock cycle when the output is not stalled: an input register feeds
// the decision logic, whose result and the new switch state are registered together,
// so a result reaches the outputs through the input register and then the output
// register. The output register holds a result until it is taken while the input
// register can still take one more word, and both stall only when both are full.
module dst_switch_controller
    import dstc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] month,
    input  logic [4:0] day,
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    input  logic [5:0] second,
    input  logic [2:0] last_day_weekday,
    input  logic       saved_dst,

    output logic       out_valid,
    input  logic       out_ready,
    output logic       dst_now,
    output logic       set_clock,
    output logic [4:0] clock_hour,
    output logic [5:0] clock_minute,
    output logic [5:0] clock_second,
    output logic       save_dst,
    output logic       save_dst_value
);

    dstc_item_t   item_reg;
    logic         item_valid_reg;
    dstc_state_t  state_reg;
    dstc_state_t  state_next;
    dstc_result_t result_next;
    dstc_result_t result_reg;
    logic         out_valid_reg;
    logic         advance;

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    dstc_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '{dst_flag: 1'b0, spring_phase: PH_WAIT, autumn_phase: PH_WAIT};
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= '{month: month, day: day, hour: hour, minute: minute,
                          second: second, last_day_weekday: last_day_weekday,
                          saved_dst: saved_dst};
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign dst_now        = result_reg.dst_now;
    assign set_clock      = result_reg.set_clock;
    assign clock_hour     = result_reg.clock_hour;
    assign clock_minute   = result_reg.clock_minute;
    assign clock_second   = result_reg.clock_second;
    assign save_dst       = result_reg.save_dst;
    assign save_dst_value = result_reg.save_dst_value;

endmodule
